// ----- sv/q6k_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_pkg
// Shared types, widths and codes of the 6-bit quantized row dot product.
// ----------------------------------------------------------------------------
package q6k_pkg;

  // super-block geometry
  localparam int SUPER_BLOCK_ELEMS = 256;
  localparam int LANES            = 4;
  localparam int GROUPS_PER_BLOCK = SUPER_BLOCK_ELEMS / LANES;
  localparam int GI_W             = $clog2(GROUPS_PER_BLOCK);
  localparam int SUB_SCALES       = 16;
  localparam int SCALES_PER_LANE  = SUB_SCALES / LANES;
  localparam int SEL_W            = $clog2(SCALES_PER_LANE);

  // datapath widths
  localparam int CODE_W  = 6;
  localparam int SCALE_W = 8;
  localparam int ACT_W   = 16;
  localparam int SQ_W    = SCALE_W + CODE_W;
  localparam int PROD_W  = SQ_W + ACT_W;
  localparam int PART_W  = 40;
  localparam int MANT_W  = 12;
  localparam int FPROD_W = PART_W + MANT_W;
  localparam int SH_W    = 8;
  localparam int ACC_W   = 64;

  // configuration port
  localparam int AFB_W      = 4;
  localparam int SFB_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [AFB_W-1:0] AFB_RESET = 4'd12;
  localparam logic [SFB_W-1:0] SFB_RESET = 6'd16;

  // fp16 scale decode
  localparam logic [4:0]             FP16_EXP_SPECIAL = 5'h1f;
  localparam logic signed [SH_W-1:0] EXP_BIAS         = 8'sd25;

  // item kinds
  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_GROUP  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACT_FRAC = 2'd0,
    CFG_SUM_FRAC = 2'd1
  } q6k_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_FMUL,
    ST_FSHIFT,
    ST_FADD,
    ST_EMIT
  } q6k_state_e;

  typedef struct packed {
    logic                    mode;
    logic [15:0]             scale_bits;
    logic [63:0]             sub_scales_low;
    logic [63:0]             sub_scales_high;
    logic [7:0]              low_byte_a;
    logic [7:0]              low_byte_b;
    logic [7:0]              high_byte;
    logic signed [ACT_W-1:0] act_0;
    logic signed [ACT_W-1:0] act_1;
    logic signed [ACT_W-1:0] act_2;
    logic signed [ACT_W-1:0] act_3;
    logic                    row_end;
  } q6k_in_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] row_sum;
    logic                    saturated;
    logic                    bad_scale;
  } q6k_out_t;

  typedef struct packed {
    logic load_scales;
    logic issue;
  } q6k_lane_ctrl_t;

  typedef struct packed {
    logic clear;
    logic add;
  } q6k_merge_ctrl_t;

  typedef struct packed {
    logic load_scale;
    logic mul;
    logic shift;
    logic add;
    logic clear;
  } q6k_fold_ctrl_t;

endpackage

// ----- sv/q6k_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_lane
// One weight lane: holds its four sub-block scales and forms
// scale * q * act over two multiplier stages.
// ----------------------------------------------------------------------------
module q6k_lane (
  input  logic                                           clk_i,
  input  q6k_pkg::q6k_lane_ctrl_t                        ctrl_i,
  input  logic [q6k_pkg::SCALES_PER_LANE-1:0][q6k_pkg::SCALE_W-1:0] scales_i,
  input  logic [q6k_pkg::SEL_W-1:0]                      sel_i,
  input  logic [q6k_pkg::CODE_W-1:0]                     code_i,
  input  logic signed [q6k_pkg::ACT_W-1:0]               act_i,
  output logic signed [q6k_pkg::PROD_W-1:0]              prod_o
);
  import q6k_pkg::*;

  logic [SCALE_W-1:0]        scale_mem_q [SCALES_PER_LANE];
  logic signed [SCALE_W-1:0] scale_sel;
  logic signed [CODE_W-1:0]  weight;
  logic signed [SQ_W-1:0]    sq_q;
  logic signed [ACT_W-1:0]   act_q;
  logic signed [PROD_W-1:0]  prod_q;

  // sub-block scales, loaded by a header word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_scales) begin
      for (int j = 0; j < SCALES_PER_LANE; j++) begin
        scale_mem_q[j] <= scales_i[j];
      end
    end
  end

  // weight code minus 32 is the code with its top bit flipped
  always_comb begin
    scale_sel = $signed(scale_mem_q[sel_i]);
    weight    = $signed({~code_i[CODE_W-1], code_i[CODE_W-2:0]});
  end

  // stage 1: scale times weight
  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      sq_q  <= scale_sel * weight;
      act_q <= act_i;
    end
  end

  // stage 2: times activation
  always_ff @(posedge clk_i) begin
    prod_q <= sq_q * act_q;
  end

  assign prod_o = prod_q;

endmodule

// ----- sv/q6k_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_merge
// Adds the four lane products of a group into the exact super-block partial.
// ----------------------------------------------------------------------------
module q6k_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  q6k_pkg::q6k_merge_ctrl_t          ctrl_i,
  input  logic signed [q6k_pkg::PROD_W-1:0] prod_i [q6k_pkg::LANES],
  output logic signed [q6k_pkg::PART_W-1:0] partial_o
);
  import q6k_pkg::*;

  logic signed [PART_W-1:0] partial_q;
  logic signed [PART_W-1:0] partial_d;
  logic signed [PART_W-1:0] lane_sum;

  // sum of lanes plus running partial
  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < LANES; k++) begin
      lane_sum = lane_sum + {{(PART_W-PROD_W){prod_i[k][PROD_W-1]}}, prod_i[k]};
    end
    partial_d = partial_q;
    if (ctrl_i.clear) begin
      partial_d = '0;
    end else if (ctrl_i.add) begin
      partial_d = partial_q + lane_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
    end else begin
      partial_q <= partial_d;
    end
  end

  assign partial_o = partial_q;

endmodule

// ----- sv/q6k_fold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_fold
// Folds a finished super-block partial into the row accumulator: multiply by
// the fp16 mantissa, shift to the sum format, saturating add.
// ----------------------------------------------------------------------------
module q6k_fold (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  q6k_pkg::q6k_fold_ctrl_t           ctrl_i,
  input  logic [15:0]                       scale_bits_i,
  input  logic signed [q6k_pkg::PART_W-1:0] partial_i,
  input  logic [q6k_pkg::AFB_W-1:0]         act_frac_i,
  input  logic [q6k_pkg::SFB_W-1:0]         sum_frac_i,
  output logic signed [q6k_pkg::ACC_W-1:0]  acc_o,
  output logic                              sat_o,
  output logic                              nan_o
);
  import q6k_pkg::*;

  localparam int WIDE_W = FPROD_W + ACC_W;
  localparam logic [ACC_W-1:0] INT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] INT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic [15:0]               scale_q;
  logic                      skip_q;
  logic signed [FPROD_W-1:0] fprod_q;
  logic signed [SH_W-1:0]    sh_q;
  logic signed [ACC_W-1:0]   term_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      sat_q;
  logic                      nan_q;

  logic [4:0]                ex;
  logic [10:0]               mag;
  logic signed [MANT_W-1:0]  mant;
  logic [4:0]                eff_exp;
  logic signed [SH_W-1:0]    sh_d;
  logic                      special;

  logic [WIDE_W-1:0]         wide;
  logic [SH_W-1:0]           rsh;
  logic signed [ACC_W-1:0]   term_d;
  logic                      shift_ovf;
  logic [ACC_W:0]            sum_ext;
  logic signed [ACC_W-1:0]   acc_add;
  logic                      add_ovf;

  // fp16 decode and shift amount
  always_comb begin
    ex      = scale_q[14:10];
    special = (ex == FP16_EXP_SPECIAL);
    mag     = (ex != 5'd0) ? {1'b1, scale_q[9:0]} : {1'b0, scale_q[9:0]};
    mant    = scale_q[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    eff_exp = (ex != 5'd0) ? ex : 5'd1;
    sh_d    = $signed({2'b00, sum_frac_i}) - $signed({4'b0000, act_frac_i})
            + $signed({3'b000, eff_exp}) - EXP_BIAS;
  end

  // scaling shift: saturating left, flooring right
  always_comb begin
    wide      = {{ACC_W{fprod_q[FPROD_W-1]}}, fprod_q} << sh_q[5:0];
    rsh       = SH_W'(-sh_q);
    shift_ovf = 1'b0;
    term_d    = '0;
    if (skip_q) begin
      term_d = '0;
    end else if (!sh_q[SH_W-1]) begin
      if (fprod_q == '0) begin
        term_d = '0;
      end else if (sh_q >= 8'sd63) begin
        shift_ovf = 1'b1;
        term_d    = fprod_q[FPROD_W-1] ? INT_MIN : INT_MAX;
      end else if (wide[WIDE_W-1:ACC_W-1] != {(WIDE_W-ACC_W+1){fprod_q[FPROD_W-1]}}) begin
        shift_ovf = 1'b1;
        term_d    = fprod_q[FPROD_W-1] ? INT_MIN : INT_MAX;
      end else begin
        term_d = wide[ACC_W-1:0];
      end
    end else begin
      term_d = $signed({{(ACC_W-FPROD_W){fprod_q[FPROD_W-1]}}, fprod_q}) >>> rsh;
    end
  end

  // saturating accumulate
  always_comb begin
    sum_ext = {acc_q[ACC_W-1], acc_q} + {term_q[ACC_W-1], term_q};
    add_ovf = (sum_ext[ACC_W] != sum_ext[ACC_W-1]);
    acc_add = add_ovf ? (sum_ext[ACC_W] ? INT_MIN : INT_MAX) : sum_ext[ACC_W-1:0];
  end

  // block scale and multiplier stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      skip_q  <= 1'b0;
    end else begin
      if (ctrl_i.load_scale) begin
        scale_q <= scale_bits_i;
      end
      if (ctrl_i.mul) begin
        skip_q <= special;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      fprod_q <= partial_i * mant;
      sh_q    <= sh_d;
    end
    if (ctrl_i.shift) begin
      term_q <= term_d;
    end
  end

  // accumulator and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
      nan_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
      sat_q <= 1'b0;
      nan_q <= 1'b0;
    end else begin
      if (ctrl_i.mul && special) begin
        nan_q <= 1'b1;
      end
      if (ctrl_i.shift && shift_ovf) begin
        sat_q <= 1'b1;
      end
      if (ctrl_i.add) begin
        acc_q <= acc_add;
        if (add_ovf) begin
          sat_q <= 1'b1;
        end
      end
    end
  end

  assign acc_o = acc_q;
  assign sat_o = sat_q;
  assign nan_o = nan_q;

endmodule

// ----- sv/q6k_matrix_vector_dot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q6k_matrix_vector_dot
// Dot product of one 6-bit quantized weight row with a fixed-point
// activation vector; four weight lanes per group, folded per super-block.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               word
//  in       input      in_valid_i / in_stall_o   q6k_in_t (header or group)
//  out      output     out_valid_o / out_stall_i q6k_out_t (row sum, flags)
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  a header word is taken without leaving idle; a group word runs the two lane
//  multiplier stages, then the lane merge; the 64th group of a super-block
//  then runs the fold (mantissa multiply, shift, saturating add);
//  a row end then loads the output register.
//  reset clears control, accumulator, flags and the block scale; the
//  sub-block scales are valid only once a header has been taken.
//  out_stall_i holds the output register; a new word is still taken while a
//  result waits, and only a second row end waits for the register to free.
// ----------------------------------------------------------------------------
module q6k_matrix_vector_dot (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  q6k_pkg::q6k_in_t                  in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output q6k_pkg::q6k_out_t                 out_word_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [q6k_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [q6k_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import q6k_pkg::*;

  q6k_state_e           state_q, state_d;
  logic [GI_W-1:0]      gi_q;
  logic                 last_q;
  logic                 row_end_q;
  logic [AFB_W-1:0]     afb_q;
  logic [SFB_W-1:0]     sfb_q;
  q6k_out_t             out_q;
  logic                 out_valid_q;

  logic                 in_acc;
  logic                 hdr_acc;
  logic                 grp_acc;
  logic                 out_free;
  logic                 emit;

  q6k_lane_ctrl_t       lane_ctrl;
  q6k_merge_ctrl_t      merge_ctrl;
  q6k_fold_ctrl_t       fold_ctrl;

  logic [2*64-1:0]      all_scales;
  logic [SCALES_PER_LANE-1:0][SCALE_W-1:0] lane_scales [LANES];
  logic [CODE_W-1:0]        lane_code [LANES];
  logic signed [ACT_W-1:0]  lane_act  [LANES];
  logic signed [PROD_W-1:0] lane_prod [LANES];
  logic signed [PART_W-1:0] partial;
  logic signed [ACC_W-1:0]  acc;
  logic                     sat;
  logic                     nan;

  // handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign hdr_acc     = in_acc && (in_word_i.mode == MODE_HEADER);
  assign grp_acc     = in_acc && (in_word_i.mode == MODE_GROUP);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      afb_q <= AFB_RESET;
      sfb_q <= SFB_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (q6k_cfg_e'(cfg_index_i))
        CFG_ACT_FRAC: afb_q <= cfg_data_i[AFB_W-1:0];
        CFG_SUM_FRAC: sfb_q <= cfg_data_i[SFB_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    emit       = 1'b0;
    merge_ctrl = '0;
    fold_ctrl  = '0;
    fold_ctrl.load_scale = hdr_acc;
    merge_ctrl.clear     = hdr_acc;
    case (state_q)
      ST_IDLE: begin
        if (grp_acc) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_SUM;
      ST_SUM: begin
        merge_ctrl.add = 1'b1;
        if (last_q) begin
          state_d = ST_FMUL;
        end else if (row_end_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FMUL: begin
        fold_ctrl.mul    = 1'b1;
        merge_ctrl.clear = 1'b1;
        state_d          = ST_FSHIFT;
      end
      ST_FSHIFT: begin
        fold_ctrl.shift = 1'b1;
        state_d         = ST_FADD;
      end
      ST_FADD: begin
        fold_ctrl.add = 1'b1;
        state_d       = row_end_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit             = 1'b1;
          fold_ctrl.clear  = 1'b1;
          merge_ctrl.clear = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // group position within the super-block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gi_q      <= '0;
      last_q    <= 1'b0;
      row_end_q <= 1'b0;
    end else if (hdr_acc || emit) begin
      gi_q <= '0;
    end else if (grp_acc) begin
      gi_q      <= gi_q + 1'b1;
      last_q    <= (gi_q == GI_W'(GROUPS_PER_BLOCK - 1));
      row_end_q <= in_word_i.row_end;
    end
  end

  // lane operands
  assign all_scales = {in_word_i.sub_scales_high, in_word_i.sub_scales_low};

  for (genvar k = 0; k < LANES; k++) begin : g_scale_map
    for (genvar j = 0; j < SCALES_PER_LANE; j++) begin : g_entry
      localparam int IDX = 2 * k + (j % 2) + 8 * (j / 2);
      assign lane_scales[k][j] = all_scales[IDX*SCALE_W +: SCALE_W];
    end
  end

  always_comb begin
    lane_code[0] = {in_word_i.high_byte[1:0], in_word_i.low_byte_a[3:0]};
    lane_code[1] = {in_word_i.high_byte[3:2], in_word_i.low_byte_b[3:0]};
    lane_code[2] = {in_word_i.high_byte[5:4], in_word_i.low_byte_a[7:4]};
    lane_code[3] = {in_word_i.high_byte[7:6], in_word_i.low_byte_b[7:4]};
    lane_act[0]  = in_word_i.act_0;
    lane_act[1]  = in_word_i.act_1;
    lane_act[2]  = in_word_i.act_2;
    lane_act[3]  = in_word_i.act_3;
  end

  assign lane_ctrl.load_scales = hdr_acc;
  assign lane_ctrl.issue       = grp_acc;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    q6k_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .scales_i (lane_scales[k]),
      .sel_i    (gi_q[GI_W-1 -: SEL_W]),
      .code_i   (lane_code[k]),
      .act_i    (lane_act[k]),
      .prod_o   (lane_prod[k])
    );
  end

  q6k_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (merge_ctrl),
    .prod_i    (lane_prod),
    .partial_o (partial)
  );

  q6k_fold u_fold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (fold_ctrl),
    .scale_bits_i (in_word_i.scale_bits),
    .partial_i    (partial),
    .act_frac_i   (afb_q),
    .sum_frac_i   (sfb_q),
    .acc_o        (acc),
    .sat_o        (sat),
    .nan_o        (nan)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.row_sum   <= acc;
      out_q.saturated <= sat;
      out_q.bad_scale <= nan;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTH
  // a row end leaves accumulator, flags and group position cleared
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (acc == '0) && !sat && !nan && (gi_q == '0) && (partial == '0))
    else $error("row state not cleared after emission");

  // a fold only follows the merge of the last group of a super-block
  a_fold_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FMUL) |-> ($past(state_q) == ST_SUM) && last_q)
    else $error("fold started outside the last group");

  // the group counter has wrapped when the fold runs
  a_fold_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FMUL) |-> (gi_q == '0))
    else $error("group position not wrapped at fold");
`endif

endmodule
